FILE: src/lcadf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell average and drift filter package
// Shared widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package lcadf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_WINDOW  = 64;
  localparam int RING_AW     = $clog2(MAX_WINDOW);
  localparam int WLEN_W      = 7;
  localparam int PERIOD_W    = 8;
  localparam int THR_W       = 23;
  localparam int WSUM_W      = 31;
  localparam int ACC_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // Serial divider operand widths.
  localparam int DIV_W       = 32;
  localparam int DIVISOR_W   = 8;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_THRESH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARE_OFFSET   = 2'd3;

  localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RESET = 7'd16;
  localparam logic [PERIOD_W-1:0] CORR_PERIOD_RESET   = 8'd10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

endpackage

FILE: src/lcadf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell filter serial divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lcadf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lcadf_pkg::DIV_W-1:0]  dividend,
  input  logic        [lcadf_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic signed [lcadf_pkg::DIV_W-1:0]  quotient
);
  import lcadf_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic                 neg;
  logic [DIVISOR_W-1:0] dsor;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;

  logic [DIVISOR_W:0]   rem_shift;
  logic                 take;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIV_W-1:0]     quo_next;
  logic [DIV_W-1:0]     magnitude;

  always_comb begin
    magnitude = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
    rem_shift = {rem, quo[DIV_W-1]};
    take      = rem_shift >= {1'b0, dsor};
    rem_next  = take ? DIVISOR_W'(rem_shift - {1'b0, dsor}) : rem_shift[DIVISOR_W-1:0];
    quo_next  = {quo[DIV_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        neg   <= dividend[DIV_W-1];
        dsor  <= divisor;
        quo   <= magnitude;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= quo_next;
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? $signed(DIV_W'(-quo_next)) : $signed(quo_next);
        end
      end
    end
  end

endmodule

FILE: src/load_cell_average_drift_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell average and drift filter
// Ring-buffer moving average with period-based drift correction.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  input    | in_valid/in_ready  | sample
//  output   | out_valid/out_ready| average, net_value, correction, period_done
//  config   | cfg_we             | cfg_index, cfg_data
//
// Each request passes through the read, start, divide, apply and net steps
// until its result is loaded; the two serial dividers run side by side.
// The next request can be accepted in the cycle after the result register is
// loaded, so a new request is never taken while one is in progress.
// A result waits in the output register while out_ready is low; the block
// holds in its last step until that register is free.
// Reset is synchronous; the sample ring needs no clearing pass.
// ----------------------------------------------------------------------------
module load_cell_average_drift_filter_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [lcadf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcadf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lcadf_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lcadf_pkg::SAMPLE_BITS-1:0] average,
  output logic signed [lcadf_pkg::ACC_W-1:0]     net_value,
  output logic signed [lcadf_pkg::ACC_W-1:0]     correction,
  output logic                                   period_done
);
  import lcadf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_START, ST_DIV, ST_APPLY, ST_NET
  } state_t;

  function automatic logic [WLEN_W-1:0] eff_window(input logic [WLEN_W-1:0] w);
    logic [WLEN_W-1:0] r;
    if (w == '0) r = WLEN_W'(1);
    else if (w > WLEN_W'(MAX_WINDOW)) r = WLEN_W'(MAX_WINDOW);
    else r = w;
    return r;
  endfunction

  state_t state;

  logic [WLEN_W-1:0]     window_length;
  logic [PERIOD_W-1:0]   correction_period;
  logic [THR_W-1:0]      correction_threshold_raw;
  sample_t               tare_offset;

  sample_t               sample_ring [MAX_WINDOW];
  sample_t               ring_rd;
  logic [RING_AW-1:0]    write_index;
  logic [WLEN_W-1:0]     fill_count;
  logic signed [WSUM_W-1:0] window_sum;
  logic [PERIOD_W-1:0]   period_count;
  acc_t                  period_sum;
  sample_t               previous_period_average;
  acc_t                  drift_correction;
  sample_t               s_reg;
  logic                  closed;

  logic                  div_start;
  logic                  win_done;
  logic                  per_done;
  acc_t                  win_quo;
  acc_t                  per_quo;

  logic [WLEN_W-1:0]     win;
  logic [PERIOD_W-1:0]   period_eff;
  logic                  filling;
  logic signed [WSUM_W-1:0] window_sum_next;
  logic [WLEN_W-1:0]     fill_count_next;
  logic [WLEN_W-1:0]     idx_inc;
  logic [RING_AW-1:0]    write_index_next;
  acc_t                  period_sum_next;
  logic [PERIOD_W-1:0]   period_count_next;
  sample_t               pavg;
  logic signed [SAMPLE_BITS:0] delta;
  logic signed [SAMPLE_BITS+1:0] delta_w;
  logic signed [SAMPLE_BITS+1:0] thr_w;
  logic                  in_band;
  logic signed [ACC_W:0] corr_sum;
  acc_t                  corr_sat;
  logic signed [ACC_W+1:0] net_sum;
  acc_t                  net_sat;

  always_comb begin
    win               = eff_window(window_length);
    period_eff        = (correction_period == '0) ? PERIOD_W'(1) : correction_period;
    filling           = fill_count < win;
    window_sum_next   = window_sum + WSUM_W'(s_reg)
                        - (filling ? WSUM_W'(0) : WSUM_W'(ring_rd));
    fill_count_next   = filling ? WLEN_W'(fill_count + 1'b1) : fill_count;
    idx_inc           = WLEN_W'(write_index) + 1'b1;
    write_index_next  = (idx_inc >= win) ? '0 : idx_inc[RING_AW-1:0];
    period_sum_next   = period_sum + ACC_W'(s_reg);
    period_count_next = PERIOD_W'(period_count + 1'b1);

    pavg     = per_quo[SAMPLE_BITS-1:0];
    delta    = {pavg[SAMPLE_BITS-1], pavg}
               - {previous_period_average[SAMPLE_BITS-1], previous_period_average};
    delta_w  = {delta[SAMPLE_BITS], delta};
    thr_w    = $signed({3'b000, correction_threshold_raw});
    in_band  = (delta_w > -thr_w) && (delta_w < thr_w);
    corr_sum = {drift_correction[ACC_W-1], drift_correction}
               + {{(ACC_W-SAMPLE_BITS){delta[SAMPLE_BITS]}}, delta};
    if (corr_sum[ACC_W] != corr_sum[ACC_W-1]) begin
      corr_sat = corr_sum[ACC_W] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                                 : $signed({1'b0, {(ACC_W-1){1'b1}}});
    end else begin
      corr_sat = corr_sum[ACC_W-1:0];
    end

    net_sum = (ACC_W+2)'($signed(win_quo[SAMPLE_BITS-1:0]))
              - (ACC_W+2)'(tare_offset) - (ACC_W+2)'(drift_correction);
    if (net_sum[ACC_W+1:ACC_W-1] != '0 && net_sum[ACC_W+1:ACC_W-1] != '1) begin
      net_sat = net_sum[ACC_W+1] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                                 : $signed({1'b0, {(ACC_W-1){1'b1}}});
    end else begin
      net_sat = net_sum[ACC_W-1:0];
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign div_start = (state == ST_START);

  always_ff @(posedge clk) begin
    ring_rd <= sample_ring[write_index];
    if (state == ST_READ) begin
      sample_ring[write_index] <= s_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                    <= ST_IDLE;
      out_valid                <= 1'b0;
      window_length            <= WINDOW_LENGTH_RESET;
      correction_period        <= CORR_PERIOD_RESET;
      correction_threshold_raw <= '0;
      tare_offset              <= '0;
      write_index              <= '0;
      fill_count               <= '0;
      window_sum               <= '0;
      period_count             <= '0;
      period_sum               <= '0;
      previous_period_average  <= '0;
      drift_correction         <= '0;
      closed                   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_NET) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: begin
            if (eff_window(cfg_data[WLEN_W-1:0]) != win) begin
              write_index <= '0;
              fill_count  <= '0;
              window_sum  <= '0;
            end
            window_length <= cfg_data[WLEN_W-1:0];
          end
          REG_CORR_PERIOD: correction_period        <= cfg_data[PERIOD_W-1:0];
          REG_CORR_THRESH: correction_threshold_raw <= cfg_data[THR_W-1:0];
          REG_TARE_OFFSET: tare_offset              <= $signed(cfg_data[SAMPLE_BITS-1:0]);
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            s_reg <= sample;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          window_sum   <= window_sum_next;
          fill_count   <= fill_count_next;
          write_index  <= write_index_next;
          period_sum   <= period_sum_next;
          period_count <= period_count_next;
          closed       <= period_count_next >= period_eff;
          state        <= ST_START;
        end
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (win_done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (closed) begin
            if (in_band) begin
              drift_correction <= corr_sat;
            end
            previous_period_average <= pavg;
            period_count            <= '0;
            period_sum              <= '0;
          end
          state <= ST_NET;
        end
        ST_NET: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            average     <= win_quo[SAMPLE_BITS-1:0];
            net_value   <= net_sat;
            correction  <= drift_correction;
            period_done <= closed;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lcadf_div u_win_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ACC_W'(window_sum)),
    .divisor  (DIVISOR_W'(fill_count)),
    .done     (win_done),
    .quotient (win_quo)
  );

  lcadf_div u_per_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (period_sum),
    .divisor  (period_count),
    .done     (per_done),
    .quotient (per_quo)
  );

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    win_done == per_done)
    else $error("window and period dividers out of step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win)
    else $error("fill count exceeds window");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    WLEN_W'(write_index) < win)
    else $error("write index outside window");

  a_period_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (period_count != '1))
    else $error("period count at limit while idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    win_done |-> (state == ST_DIV))
    else $error("divider finished outside divide step");

endmodule
